>>> hw/rtl/ctq_pkg.sv
// shared types and constants for the can transmit queue scheduler
`timescale 1ns / 1ps

package ctq_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int SLOT_W     = $clog2(FIFO_DEPTH);
   localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] OP_ENQ_STD = 2'd0;
   localparam logic [1:0] OP_ENQ_EXT = 2'd1;
   localparam logic [1:0] OP_SERVICE = 2'd2;

   localparam logic [3:0] MAX_LEN = 4'd8;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 144;

   typedef struct packed {
      logic [4:0]  queued_count;
      logic        bus_reinit;
      logic        tx_clear_request;
      logic [3:0]  tx_length;
      logic [63:0] tx_payload;
      logic        tx_extended;
      logic [28:0] tx_id;
      logic        tx_start;
      logic [31:0] overflow_count;
      logic        accepted;
   } rsp_type;

endpackage

>>> hw/rtl/can_transmit_queue_scheduler.sv
// can transmit frame queue with a two-state sender, frames kept in block memory
`timescale 1ns / 1ps

// A request is an enqueue of a standard or extended frame (tuser 0 or 1) or a service
// tick (tuser 2); each request gives exactly one response. The response of an enqueue,
// or of a service tick that launches nothing, is built in the pending register and moves
// on to the output register when that is free or drained; a service tick that pops a frame
// first passes the ST_READ state, because the frame is read from the header and payload
// memories, which have registered reads. One request is worked at a time: the input is
// ready again in the cycle after the response moves to the output register, so no new
// request is taken while a response is still pending, but a new request is taken while the previous
// response still waits at the output register. Frames live in a ring of
// ctq_pkg::FIFO_DEPTH slots; a full queue refuses the frame, counts the overflow and is
// flushed. Payload bytes beyond the clamped length are stored as zero.
module can_transmit_queue_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // frame_id, payload, data_length, tx_complete, bus_off, zero fill
   input  logic [ctq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // accepted, overflow_count, tx_start, tx_id, tx_extended, tx_payload,
   // tx_length, tx_clear_request, bus_reinit, queued_count, zero fill
   output logic [ctq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type                    state_ff, state_in;
   logic [ctq_pkg::SLOT_W-1:0]   wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in;
   logic                         wr_wrap_ff, wr_wrap_in, rd_wrap_ff, rd_wrap_in;
   logic                         waiting_ff, waiting_in;
   logic [31:0]                  ovf_ff, ovf_in;
   ctq_pkg::rsp_type             pend_ff, pend_in, out_ff, out_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic                         out_valid_ff, out_valid_in;

   // frame memories
   logic [33:0]                  hdr_mem [ctq_pkg::FIFO_DEPTH];
   logic [63:0]                  pay_mem [ctq_pkg::FIFO_DEPTH];
   logic [33:0]                  hdr_rd_ff;
   logic [63:0]                  pay_rd_ff;
   logic                         mem_we, mem_re;
   logic [33:0]                  hdr_wdata;
   logic [63:0]                  pay_wdata;

   logic [1:0]                   op;
   logic [28:0]                  f_id;
   logic [63:0]                  f_payload;
   logic [3:0]                   f_len, len_c;
   logic                         f_done, f_busoff;
   logic                         accept, is_enq, is_svc, do_pop;
   logic [ctq_pkg::FILL_W-1:0]   fill_now, fill_next;
   logic [31:0]                  fill32;
   logic                         move;

   function automatic logic [ctq_pkg::FILL_W-1:0] fill_of(
      input logic [ctq_pkg::SLOT_W-1:0] ws,
      input logic                       ww,
      input logic [ctq_pkg::SLOT_W-1:0] rs,
      input logic                       rw
   );
      logic [ctq_pkg::FILL_W-1:0] d;
      d = ctq_pkg::FILL_W'(ws) - ctq_pkg::FILL_W'(rs);
      if (ws < rs || (ws == rs && ww != rw)) begin
         d = d + ctq_pkg::FILL_W'(ctq_pkg::FIFO_DEPTH);
      end
      return d;
   endfunction

   function automatic logic [ctq_pkg::SLOT_W-1:0] slot_inc(
      input logic [ctq_pkg::SLOT_W-1:0] s
   );
      logic [ctq_pkg::SLOT_W-1:0] n;
      if (s == ctq_pkg::SLOT_W'(ctq_pkg::FIFO_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = s + 1'b1;
      end
      return n;
   endfunction

   assign op        = req_tuser;
   assign f_id      = req_tdata[28:0];
   assign f_payload = req_tdata[92:29];
   assign f_len     = req_tdata[96:93];
   assign f_done    = req_tdata[97];
   assign f_busoff  = req_tdata[98];

   assign req_tready = (state_ff == ST_IDLE) && !pend_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign is_enq     = (op == ctq_pkg::OP_ENQ_STD) || (op == ctq_pkg::OP_ENQ_EXT);
   assign is_svc     = (op == ctq_pkg::OP_SERVICE);
   assign fill_now   = fill_of(wr_slot_ff, wr_wrap_ff, rd_slot_ff, rd_wrap_ff);
   assign do_pop     = accept && is_svc && !waiting_ff && (fill_now != '0);
   assign len_c      = (f_len > ctq_pkg::MAX_LEN) ? ctq_pkg::MAX_LEN : f_len;
   assign move       = pend_valid_ff && (!out_valid_ff || rsp_tready);

   always_comb begin
      pay_wdata = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < len_c) begin
            pay_wdata[8*i +: 8] = f_payload[8*i +: 8];
         end
      end
      hdr_wdata = {len_c, (op == ctq_pkg::OP_ENQ_EXT),
                   (op == ctq_pkg::OP_ENQ_EXT) ? f_id : {18'd0, f_id[10:0]}};
   end

   always_comb begin
      state_in      = state_ff;
      wr_slot_in    = wr_slot_ff;
      wr_wrap_in    = wr_wrap_ff;
      rd_slot_in    = rd_slot_ff;
      rd_wrap_in    = rd_wrap_ff;
      waiting_in    = waiting_ff;
      ovf_in        = ovf_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      fill_next     = '0;
      fill32        = '0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (move) begin
         out_in        = pend_ff;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in = '0;
               if (is_enq) begin
                  if (fill_now == ctq_pkg::FILL_W'(ctq_pkg::FIFO_DEPTH)) begin
                     // refused: count it and flush the queue
                     ovf_in     = ovf_ff + 32'd1;
                     rd_slot_in = wr_slot_ff;
                     rd_wrap_in = wr_wrap_ff;
                  end else begin
                     mem_we           = 1'b1;
                     wr_slot_in       = slot_inc(wr_slot_ff);
                     wr_wrap_in       = (wr_slot_ff ==
                        ctq_pkg::SLOT_W'(ctq_pkg::FIFO_DEPTH - 1)) ? !wr_wrap_ff : wr_wrap_ff;
                     pend_in.accepted = 1'b1;
                  end
               end else if (is_svc) begin
                  if (do_pop) begin
                     mem_re           = 1'b1;
                     rd_slot_in       = slot_inc(rd_slot_ff);
                     rd_wrap_in       = (rd_slot_ff ==
                        ctq_pkg::SLOT_W'(ctq_pkg::FIFO_DEPTH - 1)) ? !rd_wrap_ff : rd_wrap_ff;
                     waiting_in       = 1'b1;
                     pend_in.tx_start = 1'b1;
                  end else if (waiting_ff && f_done) begin
                     waiting_in               = 1'b0;
                     pend_in.tx_clear_request = 1'b1;
                  end
                  pend_in.bus_reinit = f_busoff;
               end
               pend_in.overflow_count = ovf_in;
               fill_next = fill_of(wr_slot_in, wr_wrap_in, rd_slot_in, rd_wrap_in);
               fill32    = 32'(fill_next);
               pend_in.queued_count = fill32[4:0];
               if (do_pop) begin
                  state_in = ST_READ;
               end else begin
                  pend_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            // memory data for the popped slot is here now
            pend_in.tx_id       = hdr_rd_ff[28:0];
            pend_in.tx_extended = hdr_rd_ff[29];
            pend_in.tx_length   = hdr_rd_ff[33:30];
            pend_in.tx_payload  = pay_rd_ff;
            pend_valid_in       = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_slot_ff    <= '0;
         wr_wrap_ff    <= 1'b0;
         rd_slot_ff    <= '0;
         rd_wrap_ff    <= 1'b0;
         waiting_ff    <= 1'b0;
         ovf_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_slot_ff    <= wr_slot_in;
         wr_wrap_ff    <= wr_wrap_in;
         rd_slot_ff    <= rd_slot_in;
         rd_wrap_ff    <= rd_wrap_in;
         waiting_ff    <= waiting_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hdr_mem[wr_slot_ff] <= hdr_wdata;
         pay_mem[wr_slot_ff] <= pay_wdata;
      end
      if (mem_re) begin
         hdr_rd_ff <= hdr_mem[rd_slot_ff];
         pay_rd_ff <= pay_mem[rd_slot_ff];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.queued_count, out_ff.bus_reinit,
                        out_ff.tx_clear_request, out_ff.tx_length, out_ff.tx_payload,
                        out_ff.tx_extended, out_ff.tx_id, out_ff.tx_start,
                        out_ff.overflow_count, out_ff.accepted};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_now <= ctq_pkg::FILL_W'(ctq_pkg::FIFO_DEPTH))
      else $error("queue fill level beyond depth");

   a_pop_reads: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> (state_ff == ST_READ) && !pend_valid_ff && waiting_ff)
      else $error("pop did not enter memory read");

   a_plain_result: assert property (@(posedge clock) disable iff (reset)
      (accept && !do_pop) |=> pend_valid_ff && (state_ff == ST_IDLE))
      else $error("request without pop gave no pending response");

   a_launch_len: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && pend_ff.tx_start) |-> (pend_ff.tx_length <= ctq_pkg::MAX_LEN))
      else $error("launched frame length above eight");

endmodule
